// ===== hw/rtl/hse_pkg.sv =====
// ----------------------------------------------------------------------------
// hse_pkg
// Shared widths, command codes and defaults of the Huffman stream encoder.
// ----------------------------------------------------------------------------
package hse_pkg;

   localparam int CMD_W  = 2;
   localparam int SYM_W  = 8;
   localparam int LEN_W  = 6;
   localparam int CODE_W = 32;
   localparam int BYTE_W = 8;
   localparam int PAD_W  = 3;

   localparam int DEF_MAX_CODE_BITS = 32;
   localparam int DEF_SYMBOLS       = 256;

   localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ENCODE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd2;

   // lookup stage to packer: one staged item
   typedef struct packed {
      logic valid;
      logic flush;
   } hse_item_ctrl_type;

endpackage

// ===== hw/rtl/hse_req_if.sv =====
// ----------------------------------------------------------------------------
// hse_req_if
// Request channel: command, symbol and code table load data.
// ----------------------------------------------------------------------------
interface hse_req_if import hse_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [SYM_W-1:0]  symbol;
   logic [LEN_W-1:0]  code_length;
   logic [CODE_W-1:0] code_bits;

   modport source (output valid, command, symbol, code_length, code_bits, input ready);
   modport sink   (input valid, command, symbol, code_length, code_bits, output ready);
endinterface

// ===== hw/rtl/hse_rsp_if.sv =====
// ----------------------------------------------------------------------------
// hse_rsp_if
// Response channel: packed output bytes and the pad count.
// ----------------------------------------------------------------------------
interface hse_rsp_if import hse_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              is_pad_count;
   logic              last;

   modport source (output valid, out_byte, is_pad_count, last, input ready);
   modport sink   (input valid, out_byte, is_pad_count, last, output ready);
endinterface

// ===== hw/rtl/hse_lookup.sv =====
// ----------------------------------------------------------------------------
// hse_lookup
// Code table memory and request stage: write on load, registered read on
// encode, staged item handed to the packer.
// ----------------------------------------------------------------------------
module hse_lookup import hse_pkg::*; #(
   parameter  int MAX_CODE_BITS = DEF_MAX_CODE_BITS,
   parameter  int SYMBOLS       = DEF_SYMBOLS,
   localparam int LIM           = (MAX_CODE_BITS < CODE_W) ? MAX_CODE_BITS : CODE_W
) (
   input  logic              clock,
   input  logic              reset,
   hse_req_if.sink           req_if,
   output hse_item_ctrl_type item_ctrl,
   input  logic              item_ready,
   output logic [LEN_W-1:0]  item_len,
   output logic [LIM-1:0]    item_code
);

   localparam int ADDR_W = $clog2(SYMBOLS);
   localparam logic [LEN_W-1:0] LEN_LIM = LEN_W'(LIM);

   logic [LEN_W+LIM-1:0] mem [SYMBOLS];

   logic [SYMBOLS-1:0] hit_ff, hit_in;
   logic               a_valid_ff, a_valid_in;
   logic               a_flush_ff;
   logic               rd_hit_ff;
   logic [LEN_W-1:0]   rd_len_ff;
   logic [LIM-1:0]     rd_code_ff;

   logic              accept;
   logic              in_range;
   logic [ADDR_W-1:0] addr;
   logic [LEN_W-1:0]  len_sat;
   logic [CODE_W-1:0] code_shift;
   logic [LIM-1:0]    code_la;
   logic              do_write;
   logic              do_read;
   logic              do_flush;

   assign req_if.ready = !a_valid_ff || item_ready;
   assign accept       = req_if.valid && req_if.ready;
   assign in_range     = {1'b0, req_if.symbol} < (SYM_W + 1)'(SYMBOLS);
   assign addr         = req_if.symbol[ADDR_W-1:0];

   // saturate the length, then left-align the code so the packer only shifts right
   assign len_sat    = (req_if.code_length > LEN_LIM) ? LEN_LIM : req_if.code_length;
   assign code_shift = req_if.code_bits << (LEN_W'(CODE_W) - len_sat);
   assign code_la    = code_shift[CODE_W-1 -: LIM];

   assign do_write = accept && (req_if.command == CMD_LOAD) && in_range;
   assign do_read  = accept && (req_if.command == CMD_ENCODE) && in_range;
   assign do_flush = accept && (req_if.command == CMD_FLUSH);

   always_comb begin
      hit_in = hit_ff;
      if (do_write) begin
         hit_in = hit_ff | (SYMBOLS'(1) << addr);
      end
      a_valid_in = a_valid_ff && !item_ready;
      if (do_read || do_flush) begin
         a_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff     <= '0;
         a_valid_ff <= 1'b0;
      end else begin
         hit_ff     <= hit_in;
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_flush_ff <= do_flush;
      end
      if (do_write) begin
         mem[addr] <= {len_sat, code_la};
      end
      if (do_read) begin
         {rd_len_ff, rd_code_ff} <= mem[addr];
         rd_hit_ff               <= hit_ff[addr];
      end
   end

   // an entry never loaded reads as length zero
   assign item_ctrl.valid = a_valid_ff;
   assign item_ctrl.flush = a_flush_ff;
   assign item_len        = rd_hit_ff ? rd_len_ff : '0;
   assign item_code       = rd_hit_ff ? rd_code_ff : '0;

endmodule

// ===== hw/rtl/hse_packer.sv =====
// ----------------------------------------------------------------------------
// hse_packer
// MSB-first bit packer: merges staged codes, emits one byte per cycle into
// the response register while the receiver takes them, handles flush padding.
// ----------------------------------------------------------------------------
module hse_packer import hse_pkg::*; #(
   parameter  int MAX_CODE_BITS = DEF_MAX_CODE_BITS,
   localparam int LIM           = (MAX_CODE_BITS < CODE_W) ? MAX_CODE_BITS : CODE_W
) (
   input  logic              clock,
   input  logic              reset,
   input  hse_item_ctrl_type item_ctrl,
   output logic              item_ready,
   input  logic [LEN_W-1:0]  item_len,
   input  logic [LIM-1:0]    item_code,
   hse_rsp_if.source         rsp_if
);

   localparam int BUF_W = LIM + BYTE_W;
   localparam int CNT_W = $clog2(BUF_W + 1);

   logic [BUF_W-1:0]  work_ff, work_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              flush_ff, flush_in;
   logic [PAD_W-1:0]  pad_ff, pad_in;
   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic              out_pad_ff, out_pad_in;
   logic              out_last_ff, out_last_in;

   logic              out_free;
   logic [CNT_W-1:0]  cnt_sub;
   logic              have;
   logic              fire;
   logic              take;
   logic [BYTE_W-1:0] e_byte;
   logic              e_pad;
   logic              e_last;
   logic [BUF_W-1:0]  post_work;
   logic [CNT_W-1:0]  post_cnt;
   logic              post_flush;

   assign out_free = !out_valid_ff || rsp_if.ready;
   assign cnt_sub  = cnt_ff - CNT_W'(BYTE_W);

   always_comb begin
      have   = 1'b0;
      e_byte = work_ff[BUF_W-1 -: BYTE_W];
      e_pad  = 1'b0;
      e_last = 1'b0;
      priority if (cnt_ff >= CNT_W'(BYTE_W)) begin
         have   = 1'b1;
         e_last = cnt_sub < CNT_W'(BYTE_W);
      end else if (flush_ff && (cnt_ff != '0)) begin
         have = 1'b1;
      end else if (flush_ff) begin
         have   = 1'b1;
         e_byte = BYTE_W'(pad_ff);
         e_pad  = 1'b1;
         e_last = 1'b1;
      end else begin
         have = 1'b0;
      end
      fire = have && out_free;

      // state after this cycle's byte, before merging a new item
      post_work  = work_ff;
      post_cnt   = cnt_ff;
      post_flush = flush_ff;
      if (fire) begin
         if (cnt_ff >= CNT_W'(BYTE_W)) begin
            post_work = work_ff << BYTE_W;
            post_cnt  = cnt_sub;
         end else begin
            post_work  = '0;
            post_cnt   = '0;
            post_flush = cnt_ff != '0;
         end
      end

      item_ready = (post_cnt < CNT_W'(BYTE_W)) && !post_flush;
      take       = item_ctrl.valid && item_ready;

      work_in  = post_work;
      cnt_in   = post_cnt;
      flush_in = post_flush;
      pad_in   = pad_ff;
      if (take) begin
         if (item_ctrl.flush) begin
            flush_in = 1'b1;
            pad_in   = PAD_W'(0) - post_cnt[PAD_W-1:0];
         end else begin
            work_in = post_work | ({item_code, BYTE_W'(0)} >> post_cnt[PAD_W-1:0]);
            cnt_in  = post_cnt + CNT_W'(item_len);
         end
      end

      out_valid_in = fire || (out_valid_ff && !rsp_if.ready);
      out_byte_in  = out_byte_ff;
      out_pad_in   = out_pad_ff;
      out_last_in  = out_last_ff;
      if (fire) begin
         out_byte_in = e_byte;
         out_pad_in  = e_pad;
         out_last_in = e_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_ff      <= '0;
         cnt_ff       <= '0;
         flush_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         work_ff      <= work_in;
         cnt_ff       <= cnt_in;
         flush_ff     <= flush_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pad_ff      <= pad_in;
      out_byte_ff <= out_byte_in;
      out_pad_ff  <= out_pad_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.out_byte     = out_byte_ff;
   assign rsp_if.is_pad_count = out_pad_ff;
   assign rsp_if.last         = out_last_ff;

endmodule

// ===== hw/rtl/huffman_stream_encoder.sv =====
// Encode and flush requests reach the response via lookup, packer and output registers.
// One request per cycle is taken while each emits at most one byte and the receiver keeps
// up; a request with more bytes holds the packer until the single byte-wide path sends them.
// The code table is a one-port memory: one write (load) or one read (encode) per cycle.
// Reset (synchronous, active high) clears the table's valid bits, the packer and the output
// register at once; the block takes requests in the first cycle after reset.
// ----------------------------------------------------------------------------
// huffman_stream_encoder
// Table-driven Huffman encoder with an MSB-first byte packer and flush padding.
// ----------------------------------------------------------------------------
module huffman_stream_encoder import hse_pkg::*; #(
   parameter int MAX_CODE_BITS = DEF_MAX_CODE_BITS,
   parameter int SYMBOLS       = DEF_SYMBOLS
) (
   input  logic      clock,
   input  logic      reset,
   hse_req_if.sink   req_if,
   hse_rsp_if.source rsp_if
);

   // stored codes are left-aligned in this many bits
   localparam int LIM = (MAX_CODE_BITS < CODE_W) ? MAX_CODE_BITS : CODE_W;

   hse_item_ctrl_type    item_ctrl;
   logic                 item_ready;
   logic [LEN_W-1:0]     item_len;
   logic [LIM-1:0]       item_code;

   // Stage one: decode the request, write the table on load, read it on encode.
   // Loads finish here and never reach the packer; command three and encodes of
   // symbols beyond the table are dropped.
   hse_lookup #(
      .MAX_CODE_BITS (MAX_CODE_BITS),
      .SYMBOLS       (SYMBOLS)
   ) u_lookup (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .item_ctrl  (item_ctrl),
      .item_ready (item_ready),
      .item_len   (item_len),
      .item_code  (item_code)
   );

   // Stage two: append the code to the pending bits, then drain whole bytes one per cycle
   // unless the receiver stalls. A flush emits any partial byte, then the pad count, and
   // clears. The next item merges in the same cycle the previous one sends its last byte.
   hse_packer #(
      .MAX_CODE_BITS (MAX_CODE_BITS)
   ) u_packer (
      .clock      (clock),
      .reset      (reset),
      .item_ctrl  (item_ctrl),
      .item_ready (item_ready),
      .item_len   (item_len),
      .item_code  (item_code),
      .rsp_if     (rsp_if)
   );

endmodule

// ===== hw/rtl/hse_checker.sv =====
// ----------------------------------------------------------------------------
// hse_checker
// Port-level checks of the encoder's response channel.
// ----------------------------------------------------------------------------
module hse_checker import hse_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [BYTE_W-1:0] rsp_out_byte,
   input logic              rsp_is_pad_count,
   input logic              rsp_last
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_is_pad_count) && $stable(rsp_last))
      else $error("response changed while stalled");

   // the pad count closes a flush
   a_pad_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_pad_count |-> rsp_last)
      else $error("pad count without last");

   // pad count is below one byte
   a_pad_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_pad_count |-> rsp_out_byte[BYTE_W-1:PAD_W] == '0)
      else $error("pad count out of range");

   // reset empties the output register
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind huffman_stream_encoder hse_checker u_hse_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_out_byte     (rsp_if.out_byte),
   .rsp_is_pad_count (rsp_if.is_pad_count),
   .rsp_last         (rsp_if.last)
);

// ===== verif/tb_huffman_stream_encoder.sv =====
// ----------------------------------------------------------------------------
// tb_huffman_stream_encoder
// Self-checking bench: predicts every packed byte and pad count of the encoder
// from its own table and packer copy, under several request/response stall mixes.
// ----------------------------------------------------------------------------
module tb_huffman_stream_encoder;
   import hse_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;   // spare command, must be ignored
   localparam int LEN_CAP       = (DEF_MAX_CODE_BITS < 32) ? DEF_MAX_CODE_BITS : 32;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int DRAIN_CYCLES  = 16;                // idle time after the last expected byte, to catch extra responses
   localparam int HOLD_CYCLES   = 250;
   localparam int ITEMS_PER_PH  = 64;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              is_pad_count;
      logic              last;
   } packed_byte_type;

   // Predicts the byte stream: its own copy of the code table and the packer.
   class packed_byte_model_type;
      logic [LEN_W-1:0]  code_len [DEF_SYMBOLS];
      logic [CODE_W-1:0] code_val [DEF_SYMBOLS];
      logic [6:0]        pend_bits;
      int                pend_count;
      packed_byte_type   expected_bytes [$];
      int                n_requests;
      int                n_bytes;
      int                n_errors;

      function new();
         foreach (code_len[i]) begin
            code_len[i] = '0;
            code_val[i] = '0;
         end
         pend_bits  = '0;
         pend_count = 0;
         n_requests = 0;
         n_bytes    = 0;
         n_errors   = 0;
      endfunction

      function void push_byte(logic [BYTE_W-1:0] b, logic pad, logic lst);
         packed_byte_type e;
         e.out_byte     = b;
         e.is_pad_count = pad;
         e.last         = lst;
         expected_bytes.push_back(e);
      endfunction

      function void note_request(logic [CMD_W-1:0] cmd, logic [SYM_W-1:0] sym,
                                 logic [LEN_W-1:0] len, logic [CODE_W-1:0] bits);
         logic [7:0]  acc;
         logic [7:0]  held;
         logic        have_held;
         int          cnt;
         int          clen;
         int          pad;
         n_requests++;
         unique case (cmd)
            CMD_LOAD: begin
               if (int'(sym) < DEF_SYMBOLS) begin
                  code_len[sym] = (int'(len) > LEN_CAP) ? LEN_W'(LEN_CAP) : len;
                  code_val[sym] = bits;
               end
            end
            CMD_ENCODE: begin
               if (int'(sym) < DEF_SYMBOLS) begin
                  clen      = int'(code_len[sym]);
                  acc       = {1'b0, pend_bits};
                  cnt       = pend_count;
                  have_held = 1'b0;
                  held      = '0;
                  // shift in MSB first; keep the newest byte back so it can carry last
                  for (int i = 0; i < clen; i++) begin
                     acc = {acc[6:0], code_val[sym][clen-1-i]};
                     cnt++;
                     if (cnt == 8) begin
                        if (have_held) push_byte(held, 1'b0, 1'b0);
                        held      = acc;
                        have_held = 1'b1;
                        acc       = '0;
                        cnt       = 0;
                     end
                  end
                  if (have_held) push_byte(held, 1'b0, 1'b1);
                  pend_bits  = acc[6:0];
                  pend_count = cnt;
               end
            end
            CMD_FLUSH: begin
               pad = (8 - pend_count) & 7;
               if (pend_count != 0) begin
                  acc = {1'b0, pend_bits} << (8 - pend_count);
                  push_byte(acc, 1'b0, 1'b0);
               end
               push_byte(8'(pad), 1'b1, 1'b1);
               pend_bits  = '0;
               pend_count = 0;
            end
            default: ;
         endcase
      endfunction

      function void check_response(logic [BYTE_W-1:0] b, logic pad, logic lst);
         packed_byte_type e;
         n_bytes++;
         if (expected_bytes.size() == 0) begin
            $error("unexpected response: out_byte=%0h is_pad_count=%0b last=%0b", b, pad, lst);
            n_errors++;
            return;
         end
         e = expected_bytes.pop_front();
         if (b !== e.out_byte) begin
            $error("out_byte: expected %0h, got %0h", e.out_byte, b);
            n_errors++;
         end
         if (pad !== e.is_pad_count) begin
            $error("is_pad_count: expected %0b, got %0b", e.is_pad_count, pad);
            n_errors++;
         end
         if (lst !== e.last) begin
            $error("last: expected %0b, got %0b", e.last, lst);
            n_errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   cycle_count;
   int   send_idle_pct;
   int   recv_stall_pct;
   bit   pressure_go;
   int   hold_left;

   logic [SYM_W-1:0] hot_syms [16];

   packed_byte_model_type model = new();

   hse_req_if req_bus ();
   hse_rsp_if rsp_bus ();

   huffman_stream_encoder u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus.sink),
      .rsp_if (rsp_bus.source)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Abort a hung run; the limit is many times the slowest legal run.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d bytes still expected",
                  cycle_count, model.expected_bytes.size());
         $display("FAIL huffman_stream_encoder");
         $finish;
      end
   end

   // Receiver: stall at random, or hold off for a long stretch on request
   // so the encoder backs up and drops req ready.
   initial begin
      rsp_bus.ready = 1'b0;
      hold_left     = 0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (pressure_go) begin
            pressure_go = 1'b0;
            hold_left   = HOLD_CYCLES - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // Check every accepted response against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         model.check_response(rsp_bus.out_byte, rsp_bus.is_pad_count, rsp_bus.last);
   end

   // Offer one request; idle first at the phase's rate, then hold it until accepted.
   task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [SYM_W-1:0] sym,
                               input logic [LEN_W-1:0] len, input logic [CODE_W-1:0] bits);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.command     <= cmd;
      req_bus.symbol      <= sym;
      req_bus.code_length <= len;
      req_bus.code_bits   <= bits;
      forever begin
         @(posedge clock);
         if (req_bus.ready) break;
      end
      model.note_request(cmd, sym, len, bits);
   endtask

   // Mostly short codes, some full width, some past the cap to hit saturation.
   function automatic logic [LEN_W-1:0] random_length();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return '0;
      if (pick <= 6) return LEN_W'($urandom_range(1, 12));
      if (pick == 7) return LEN_W'($urandom_range(13, 32));
      if (pick == 8) return LEN_W'($urandom_range(33, 63));
      return LEN_W'($urandom_range(1, 8));
   endfunction

   // Well-formed traffic on a small set of hot symbols, plus stray symbols and
   // the spare command as noise.
   task automatic random_request();
      int               pick;
      logic [CMD_W-1:0] cmd;
      logic [SYM_W-1:0] sym;
      pick = $urandom_range(0, 99);
      if (pick < 20)      cmd = CMD_LOAD;
      else if (pick < 85) cmd = CMD_ENCODE;
      else if (pick < 97) cmd = CMD_FLUSH;
      else                cmd = CMD_UNUSED;
      sym = ($urandom_range(0, 9) < 8) ? hot_syms[$urandom_range(0, 15)]
                                       : SYM_W'($urandom_range(0, 255));
      send_request(cmd, sym, random_length(), $urandom());
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct, input bit squeeze);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      if (squeeze) pressure_go = 1'b1;
      repeat (ITEMS_PER_PH) random_request();
   endtask

   initial begin
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.command     = CMD_LOAD;
      req_bus.symbol      = '0;
      req_bus.code_length = '0;
      req_bus.code_bits   = '0;
      send_idle_pct       = 0;
      recv_stall_pct      = 0;
      pressure_go         = 1'b0;
      foreach (hot_syms[i]) hot_syms[i] = SYM_W'($urandom_range(0, 255));

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: table extremes, saturation, empty and partial flush, spare command.
      send_request(CMD_LOAD,   8'd0,   6'd0,  32'hFFFF_FFFF);
      send_request(CMD_LOAD,   8'd1,   6'd1,  32'h0000_0001);
      send_request(CMD_LOAD,   8'd2,   6'd63, 32'hA5A5_A5A5);   // saturates to the cap
      send_request(CMD_LOAD,   8'd3,   6'd7,  32'h0000_0055);
      send_request(CMD_LOAD,   8'd255, 6'd32, 32'hFFFF_FFFF);
      send_request(CMD_LOAD,   8'd4,   6'd8,  32'h0000_0000);
      send_request(CMD_LOAD,   8'd6,   6'd33, 32'h8000_0001);   // one past the cap
      send_request(CMD_ENCODE, 8'd0,   6'd0,  32'h0);           // zero length: nothing
      send_request(CMD_ENCODE, 8'd5,   6'd63, 32'hFFFF_FFFF);   // never loaded: nothing
      send_request(CMD_FLUSH,  8'd255, 6'd0,  32'h0);           // empty packer
      send_request(CMD_ENCODE, 8'd1,   6'd0,  32'h0);           // no full byte yet
      send_request(CMD_ENCODE, 8'd3,   6'd0,  32'h0);           // completes one byte
      send_request(CMD_ENCODE, 8'd255, 6'd0,  32'h0);           // four bytes at once
      send_request(CMD_ENCODE, 8'd1,   6'd0,  32'h0);
      send_request(CMD_FLUSH,  8'd0,   6'd63, 32'hFFFF_FFFF);   // partial byte plus pad
      send_request(CMD_UNUSED, 8'd255, 6'd63, 32'hFFFF_FFFF);   // ignored
      send_request(CMD_ENCODE, 8'd2,   6'd0,  32'h0);
      send_request(CMD_ENCODE, 8'd6,   6'd0,  32'h0);
      send_request(CMD_ENCODE, 8'd4,   6'd0,  32'h0);
      send_request(CMD_ENCODE, 8'd3,   6'd0,  32'h0);
      send_request(CMD_FLUSH,  8'd0,   6'd0,  32'h0);
      send_request(CMD_LOAD,   8'd255, 6'd0,  32'h0);           // clear an entry
      send_request(CMD_ENCODE, 8'd255, 6'd0,  32'h0);
      send_request(CMD_FLUSH,  8'd0,   6'd0,  32'h0);

      // Random: free flow, sender idle, receiver stall, both, then a long hold-off.
      run_phase(0,  0,  1'b0);
      run_phase(77, 0,  1'b0);
      run_phase(0,  77, 1'b0);
      run_phase(33, 33, 1'b0);
      run_phase(0,  0,  1'b1);

      @(negedge clock);
      req_bus.valid <= 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;

      // Drain; the cycle limit catches anything that never arrives.
      while (model.expected_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests, %0d response bytes checked, %0d mismatches",
               model.n_requests, model.n_bytes, model.n_errors);
      $display("stall mixes: none, sender idle, receiver stall, both, and a %0d-cycle hold",
               HOLD_CYCLES);
      if (model.n_errors == 0) begin
         $display("PASS huffman_stream_encoder");
      end else begin
         $display("FAIL huffman_stream_encoder");
      end
      $finish;
   end

endmodule
